// ===== rtl/udc_pkg.sv =====
package udc_pkg;

  localparam int unsigned CountModulusDefault = 60;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned FlashW  = 10;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned SegW    = 7;
  localparam int unsigned BcdW    = 8;
  localparam int unsigned BinW    = 7;

  localparam logic [PeriodW-1:0] DownPeriodReset = 8'd50;
  localparam logic [PeriodW-1:0] UpPeriodReset   = 8'd20;
  localparam logic [FlashW-1:0]  FlashTicksReset = 10'd500;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DOWN_PERIOD = 2'd0,
    CFG_UP_PERIOD   = 2'd1,
    CFG_FLASH_TICKS = 2'd2
  } udc_cfg_idx_e;

  typedef struct packed {
    logic [PeriodW-1:0] down_period;
    logic [PeriodW-1:0] up_period;
    logic [FlashW-1:0]  flash_ticks;
  } udc_cfg_t;

  typedef struct packed {
    logic [SegW-1:0] segments;
    logic            show_high_digit;
    logic [BcdW-1:0] leds_bcd;
    logic            alarm_led;
  } udc_result_t;

  function automatic logic [SegW-1:0] udc_seg(input logic [3:0] digit);
    logic [SegW-1:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  // tens = v * 205 >> 11, exact for every 7-bit v (0 to 127)
  function automatic logic [BcdW-1:0] udc_to_bcd(input logic [BinW-1:0] v);
    logic [14:0]     prod;
    logic [3:0]      tens;
    logic [BinW-1:0] tens_x10;
    logic [3:0]      units;
    prod     = 15'(v) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = BinW'({tens, 3'b000}) + BinW'({tens, 1'b0});
    units    = 4'(v - tens_x10);
    return {tens, units};
  endfunction

endpackage

// ===== rtl/udc_core.sv =====
module udc_core
  import udc_pkg::*;
#(
  parameter int unsigned COUNT_MODULUS = CountModulusDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        count_up_i,
  input  udc_cfg_t    cfg_i,
  output udc_result_t result_o
);

  localparam int unsigned CountW = $clog2(COUNT_MODULUS);
  localparam logic [CountW-1:0] CountMax = CountW'(COUNT_MODULUS - 1);

  logic [CountW-1:0]  count_q, count_d;
  logic [PeriodW-1:0] tick_q, tick_d;
  logic [FlashW-1:0]  flash_q, flash_d;
  logic               toggle_q;

  logic [PeriodW-1:0] period;
  logic               boundary;
  logic [FlashW-1:0]  flash_eff;
  logic [BcdW-1:0]    bcd;
  logic               alarm;
  logic [PeriodW-1:0] tick_inc;
  logic               period_end;
  logic [CountW-1:0]  count_step;

  always_comb begin
    period    = count_up_i ? cfg_i.up_period : cfg_i.down_period;
    boundary  = count_up_i ? (count_q == CountMax) : (count_q == '0);
    flash_eff = boundary ? cfg_i.flash_ticks : flash_q;
    bcd       = udc_to_bcd(BinW'(count_q));
    alarm     = (flash_eff != '0);
    flash_d   = alarm ? flash_eff - 1'b1 : '0;

    tick_inc   = tick_q + 1'b1;
    period_end = (tick_inc >= period) || (tick_inc == '0);
    tick_d     = period_end ? '0 : tick_inc;

    if (count_up_i) begin
      count_step = (count_q == CountMax) ? '0 : count_q + 1'b1;
    end else begin
      count_step = (count_q == '0) ? CountMax : count_q - 1'b1;
    end
    count_d = period_end ? count_step : count_q;

    result_o.segments        = toggle_q ? udc_seg(bcd[3:0]) : udc_seg(bcd[7:4]);
    result_o.show_high_digit = ~toggle_q;
    result_o.leds_bcd        = bcd;
    result_o.alarm_led       = alarm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      tick_q   <= '0;
      flash_q  <= '0;
      toggle_q <= 1'b0;
    end else if (accept_i) begin
      count_q  <= count_d;
      tick_q   <= tick_d;
      flash_q  <= flash_d;
      toggle_q <= ~toggle_q;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CountMax)
    else $error("count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(count_q) && $stable(tick_q) && $stable(flash_q))
    else $error("state moved without a beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> toggle_q != $past(toggle_q))
    else $error("digit toggle did not flip");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !boundary |=> flash_q == '0 || flash_q < $past(flash_q))
    else $error("flash countdown did not drop");

endmodule

// ===== rtl/udc_outbuf.sv =====
module udc_outbuf
  import udc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  udc_result_t data_i,
  output logic        full_o,
  output logic        valid_o,
  input  logic        stall_i,
  output udc_result_t data_o
);

  localparam int unsigned Depth = 2;
  localparam logic [1:0]  CntFull = 2'(Depth);

  udc_result_t mem_q [Depth];
  logic        wr_ptr_q;
  logic        rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntFull);
  assign data_o  = mem_q[rd_ptr_q];
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("buffer count overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("beat written into full buffer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("count missed a write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push_i |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("count missed a read");

endmodule

// ===== rtl/up_down_mod60_counter_display.sv =====
// Results are registered into the output buffer as their input beats are taken.
// Throughput: one input beat per cycle; a two-entry output buffer keeps
// taking beats while fewer than two results wait, so input stalls only when full.
// Reset (asynchronous, active low): count, tick index, flash countdown and
// digit toggle clear to zero, periods load 50 and 20, flash reload loads 500.
module up_down_mod60_counter_display
  import udc_pkg::*;
#(
  parameter int unsigned COUNT_MODULUS = CountModulusDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                count_up_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SegW-1:0]     segments_o,
  output logic                show_high_digit_o,
  output logic [BcdW-1:0]     leds_bcd_o,
  output logic                alarm_led_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  udc_cfg_t    cfg_q;
  udc_result_t core_result;
  udc_result_t out_result;
  logic        buf_full;
  logic        accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = buf_full;
  assign accept      = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.down_period <= DownPeriodReset;
      cfg_q.up_period   <= UpPeriodReset;
      cfg_q.flash_ticks <= FlashTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DOWN_PERIOD: cfg_q.down_period <= cfg_data_i[PeriodW-1:0];
        CFG_UP_PERIOD:   cfg_q.up_period   <= cfg_data_i[PeriodW-1:0];
        CFG_FLASH_TICKS: cfg_q.flash_ticks <= cfg_data_i[FlashW-1:0];
        default: ;
      endcase
    end
  end

  udc_core #(
    .COUNT_MODULUS(COUNT_MODULUS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .count_up_i (count_up_i),
    .cfg_i      (cfg_q),
    .result_o   (core_result)
  );

  udc_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (core_result),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_result)
  );

  assign segments_o        = out_result.segments;
  assign show_high_digit_o = out_result.show_high_digit;
  assign leds_bcd_o        = out_result.leds_bcd;
  assign alarm_led_o       = out_result.alarm_led;

endmodule
